[rtl/ncc_pkg.sv]
// ----------------------------------------------------------------------------
// ncc_pkg: shared constants for the NCC template matcher
// Field widths, configuration register indexes, reset sizes, the similarity one value and input command codes.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_HEIGHT = 2'd3;

    localparam int IMG_DIM_W = 11;
    localparam int TPL_DIM_W = 5;

    localparam logic [IMG_DIM_W-1:0] RST_IMAGE_WIDTH     = 11'd640;
    localparam logic [IMG_DIM_W-1:0] RST_IMAGE_HEIGHT    = 11'd480;
    localparam logic [TPL_DIM_W-1:0] RST_TEMPLATE_WIDTH  = 5'd16;
    localparam logic [TPL_DIM_W-1:0] RST_TEMPLATE_HEIGHT = 5'd16;

    localparam int PIXEL_W    = 8;
    localparam int SIM_W      = 17;
    localparam int WIN_W      = 10;
    localparam int OUT_DATA_W = 40;

    localparam logic [SIM_W-1:0] SIM_ONE = 17'h10000;

    localparam logic CMD_TEMPLATE = 1'b0;
    localparam logic CMD_IMAGE    = 1'b1;

endpackage

[rtl/ncc_template_match.sv]
// ----------------------------------------------------------------------------
// ncc_template_match: normalized cross-correlation template matcher
// Row-buffered image windows correlated against a stored template.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser is the command (0 = template pixel, 1 = image pixel),
//   tdata carries the 8-bit pixel. Load the template first in raster order,
//   then stream the image in raster order.
//   Master stream: one item per complete window, named by its top-left corner;
//   tlast marks the window closed by the last pixel of the frame.
//   Configuration channel: write image/template sizes while the block is idle.
// Flow:
//   Template loads and image pixels that close no window do not hold the
//   input. A pixel that closes a window holds the input through the memory
//   reads (one template and one row-store read per cycle), then through the
//   normalization unit and until its result enters the output register.
// Reset:
//   Sizes return to 640x480 / 16x16, counters to zero. Memory contents
//   stay undefined until written.
// Stall:
//   The output register holds a finished item; input is taken meanwhile, and
//   the next finished window waits until the register drains.
// ----------------------------------------------------------------------------
module ncc_template_match #(
    parameter int MAX_TEMPLATE_W = 16,
    parameter int MAX_TEMPLATE_H = 16,
    parameter int MAX_IMAGE_W    = 1024,
    parameter int MAX_IMAGE_H    = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ncc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ncc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ncc_pkg::PIXEL_W-1:0]       s_axis_tdata,  // [7:0] pixel
    input  logic                              s_axis_tuser,  // [0] command
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [16:0] similarity, [26:17] win_x, [36:27] win_y, [39:37] zero padding
    output logic [ncc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] energy_zero
    output logic                              m_axis_tlast
);
    import ncc_pkg::*;

    localparam int TDEPTH = MAX_TEMPLATE_W * MAX_TEMPLATE_H;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int TCW    = $clog2(TDEPTH + 1);
    localparam int TWW    = $clog2(MAX_TEMPLATE_W + 1);
    localparam int THW    = $clog2(MAX_TEMPLATE_H + 1);
    localparam int IWW    = $clog2(MAX_IMAGE_W + 1);
    localparam int IHW    = $clog2(MAX_IMAGE_H + 1);
    localparam int CW     = $clog2(MAX_IMAGE_W);
    localparam int RWW    = $clog2(MAX_IMAGE_H);
    localparam int SW     = (MAX_TEMPLATE_H > 1) ? $clog2(MAX_TEMPLATE_H) : 1;
    localparam int XW     = ((SW > THW) ? SW : THW) + 1;
    localparam int RDEPTH = MAX_TEMPLATE_H * MAX_IMAGE_W;
    localparam int RAW    = $clog2(RDEPTH);
    localparam int AW     = 16 + $clog2(TDEPTH);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_MSTART, S_MWAIT, S_HOLD} t_state;

    // configuration registers, raw as written
    logic [IMG_DIM_W-1:0] r_cfg_iw, r_cfg_ih;
    logic [TPL_DIM_W-1:0] r_cfg_tw, r_cfg_th;

    // effective sizes after clamping
    logic [IWW-1:0] w_iw;
    logic [IHW-1:0] w_ih;
    logic [TWW-1:0] w_tw;
    logic [THW-1:0] w_th;
    logic [TCW-1:0] w_tcount;

    t_state         r_state;
    logic [TAW-1:0] r_tpos;
    logic [CW-1:0]  r_col;
    logic [RWW-1:0] r_row;
    logic [SW-1:0]  r_slot;        // r_row mod MAX_TEMPLATE_H

    // window scan
    logic [CW-1:0]  r_x0;
    logic [RWW-1:0] r_y0;
    logic           r_wlast;
    logic [TWW-1:0] r_tx;
    logic [THW-1:0] r_ty;
    logic [TAW-1:0] r_tidx;
    logic [SW-1:0]  r_rslot;
    logic           r_rd_v, r_rd_last;
    logic [AW-1:0]  r_acc_s, r_acc_ei, r_acc_et;

    // output register
    logic             r_out_valid;
    logic [SIM_W-1:0] r_out_sim;
    logic [WIN_W-1:0] r_out_x, r_out_y;
    logic             r_out_zero, r_out_last;

    logic             w_in_acc, w_is_img, w_clast, w_rlast, w_fire, w_issue_end;
    logic [SW-1:0]    w_slot_p1, w_slot0, w_rslot_p1;
    logic [XW-1:0]    w_slot_tmp;
    logic [RAW-1:0]   w_row_waddr, w_row_raddr;
    logic [PIXEL_W-1:0] w_tpix, w_rpix;
    logic             w_mdone, w_mzero;
    logic [SIM_W-1:0] w_msim;
    logic [2*PIXEL_W-1:0] w_tp, w_pp, w_tt;

    always_comb begin
        if (r_cfg_iw == '0)                 w_iw = IWW'(1);
        else if (r_cfg_iw > MAX_IMAGE_W)    w_iw = IWW'(MAX_IMAGE_W);
        else                                w_iw = IWW'(r_cfg_iw);
        if (r_cfg_ih == '0)                 w_ih = IHW'(1);
        else if (r_cfg_ih > MAX_IMAGE_H)    w_ih = IHW'(MAX_IMAGE_H);
        else                                w_ih = IHW'(r_cfg_ih);
        if (r_cfg_tw == '0)                 w_tw = TWW'(1);
        else if (r_cfg_tw > MAX_TEMPLATE_W) w_tw = TWW'(MAX_TEMPLATE_W);
        else                                w_tw = TWW'(r_cfg_tw);
        if (r_cfg_th == '0)                 w_th = THW'(1);
        else if (r_cfg_th > MAX_TEMPLATE_H) w_th = THW'(MAX_TEMPLATE_H);
        else                                w_th = THW'(r_cfg_th);
        w_tcount = TCW'(w_tw * w_th);
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_is_img      = (s_axis_tuser == CMD_IMAGE);

    always_comb begin
        w_clast   = ({1'b0, r_col} + 1'b1) >= w_iw;
        w_rlast   = ({1'b0, r_row} + 1'b1) >= w_ih;
        w_fire    = (({1'b0, r_col} + 1'b1) >= w_tw) && (({1'b0, r_row} + 1'b1) >= w_th);
        w_slot_p1 = (r_slot == SW'(MAX_TEMPLATE_H - 1)) ? '0 : r_slot + 1'b1;
        // slot of the window's top row: (r + 1 - th) mod MAX_TEMPLATE_H
        if (XW'(w_slot_p1) >= XW'(w_th))
            w_slot_tmp = XW'(w_slot_p1) - XW'(w_th);
        else
            w_slot_tmp = XW'(w_slot_p1) + XW'(MAX_TEMPLATE_H) - XW'(w_th);
        w_slot0     = w_slot_tmp[SW-1:0];
        w_rslot_p1  = (r_rslot == SW'(MAX_TEMPLATE_H - 1)) ? '0 : r_rslot + 1'b1;
        w_issue_end = (({1'b0, r_tx} + 1'b1) >= w_tw) && (({1'b0, r_ty} + 1'b1) >= w_th);
        w_row_waddr = RAW'(r_slot) * RAW'(MAX_IMAGE_W) + RAW'(r_col);
        w_row_raddr = RAW'(r_rslot) * RAW'(MAX_IMAGE_W) + RAW'(r_x0) + RAW'(r_tx);
        w_tp = w_tpix * w_rpix;
        w_pp = w_rpix * w_rpix;
        w_tt = w_tpix * w_tpix;
    end

    ncc_ram #(.WIDTH(PIXEL_W), .DEPTH(TDEPTH)) u_tpl_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !w_is_img && (r_tpos < TDEPTH)),
        .i_waddr (r_tpos),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_tidx),
        .o_rdata (w_tpix)
    );

    ncc_ram #(.WIDTH(PIXEL_W), .DEPTH(RDEPTH)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_is_img),
        .i_waddr (w_row_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_row_raddr),
        .o_rdata (w_rpix)
    );

    ncc_math #(.AW(AW)) u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_s     (r_acc_s),
        .i_ei    (r_acc_ei),
        .i_et    (r_acc_et),
        .o_done  (w_mdone),
        .o_sim   (w_msim),
        .o_zero  (w_mzero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_iw    <= RST_IMAGE_WIDTH;
            r_cfg_ih    <= RST_IMAGE_HEIGHT;
            r_cfg_tw    <= RST_TEMPLATE_WIDTH;
            r_cfg_th    <= RST_TEMPLATE_HEIGHT;
            r_state     <= S_IDLE;
            r_tpos      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= '0;
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:     r_cfg_iw <= i_cfg_data;
                    CFG_IMAGE_HEIGHT:    r_cfg_ih <= i_cfg_data;
                    CFG_TEMPLATE_WIDTH:  r_cfg_tw <= i_cfg_data[TPL_DIM_W-1:0];
                    CFG_TEMPLATE_HEIGHT: r_cfg_th <= i_cfg_data[TPL_DIM_W-1:0];
                    default: ;
                endcase
            end

            r_rd_v    <= (r_state == S_RUN);
            r_rd_last <= (r_state == S_RUN) && w_issue_end;

            // accumulate the products of the read pair
            if (r_rd_v) begin
                r_acc_s  <= r_acc_s  + AW'(w_tp);
                r_acc_ei <= r_acc_ei + AW'(w_pp);
                r_acc_et <= r_acc_et + AW'(w_tt);
            end

            // drop the sent item unless a new one is loaded in its place
            if (r_out_valid && m_axis_tready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && !w_is_img) begin
                        r_tpos <= (({1'b0, r_tpos} + 1'b1) >= w_tcount) ? '0 : r_tpos + 1'b1;
                    end else if (w_in_acc) begin
                        if (w_clast) begin
                            r_col <= '0;
                            if (w_rlast) begin
                                r_row  <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row  <= r_row + 1'b1;
                                r_slot <= w_slot_p1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (w_fire) begin
                            r_x0     <= CW'(({1'b0, r_col} + 1'b1) - w_tw);
                            r_y0     <= RWW'(({1'b0, r_row} + 1'b1) - w_th);
                            r_wlast  <= w_clast && w_rlast;
                            r_tx     <= '0;
                            r_ty     <= '0;
                            r_tidx   <= '0;
                            r_rslot  <= w_slot0;
                            r_acc_s  <= '0;
                            r_acc_ei <= '0;
                            r_acc_et <= '0;
                            r_state  <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    // issue one template / row-store read pair per cycle
                    r_tidx <= r_tidx + 1'b1;
                    if (({1'b0, r_tx} + 1'b1) >= w_tw) begin
                        r_tx    <= '0;
                        r_ty    <= r_ty + 1'b1;
                        r_rslot <= w_rslot_p1;
                    end else begin
                        r_tx <= r_tx + 1'b1;
                    end
                    if (w_issue_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_rd_v && r_rd_last) begin
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mdone) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // wait for the output register to drain
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_sim   <= w_msim;
                        r_out_x     <= WIN_W'(r_x0);
                        r_out_y     <= WIN_W'(r_y0);
                        r_out_zero  <= w_mzero;
                        r_out_last  <= r_wlast;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_y, r_out_x, r_out_sim};
    assign m_axis_tuser  = r_out_zero;
    assign m_axis_tlast  = r_out_last;
endmodule

[rtl/ncc_ram.sv]
// ----------------------------------------------------------------------------
// ncc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ncc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/ncc_math.sv]
// ----------------------------------------------------------------------------
// ncc_math: normalization unit
// Energy product, bit-pair square root and restoring divide, one step a cycle.
// ----------------------------------------------------------------------------
module ncc_math #(
    parameter int AW = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [AW-1:0]           i_s,
    input  logic [AW-1:0]           i_ei,
    input  logic [AW-1:0]           i_et,
    output logic                    o_done,
    output logic [ncc_pkg::SIM_W-1:0] o_sim,
    output logic                    o_zero
);
    import ncc_pkg::*;

    localparam int PW   = 2 * AW;
    localparam int DW   = AW + 16;
    localparam int CNTW = $clog2(DW + 1);

    typedef enum logic [2:0] {M_IDLE, M_MUL, M_SQRT, M_DIV, M_DONE} t_mstate;

    t_mstate           r_state;
    logic [CNTW-1:0]   r_cnt;
    logic [AW-1:0]     r_s, r_a, r_b, r_root, r_drem;
    logic [PW-1:0]     r_val;
    logic [AW+1:0]     r_srem;
    logic [DW-1:0]     r_dvd;
    logic [SIM_W-1:0]  r_sim;
    logic              r_zero;

    logic [AW+3:0]     w_st, w_ss, w_sd;
    logic              w_sge;
    logic [AW:0]       w_dt, w_dd;
    logic              w_dge;
    logic [DW-1:0]     w_q;

    always_comb begin
        w_st  = {r_srem, r_val[PW-1 -: 2]};
        w_ss  = {2'b00, r_root, 2'b01};
        w_sge = (w_st >= w_ss);
        w_sd  = w_st - w_ss;
        w_dt  = {r_drem, r_dvd[DW-1]};
        w_dge = (w_dt >= {1'b0, r_root});
        w_dd  = w_dt - {1'b0, r_root};
        w_q   = {r_dvd[DW-2:0], w_dge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_s     <= i_s;
                        r_a     <= i_ei;
                        r_b     <= i_et;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_val   <= r_a * r_b;
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNTW'(AW - 1);
                    r_state <= M_SQRT;
                end
                M_SQRT: begin
                    // one result bit per step, two radicand bits consumed
                    r_val  <= {r_val[PW-3:0], 2'b00};
                    r_srem <= w_sge ? w_sd[AW+1:0] : w_st[AW+1:0];
                    r_root <= {r_root[AW-2:0], w_sge};
                    if (r_cnt == '0) begin
                        r_state <= M_DIV;
                        r_dvd   <= {r_s, 16'h0000};
                        r_drem  <= '0;
                        r_cnt   <= CNTW'(DW - 1);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                M_DIV: begin
                    if (r_root == '0) begin
                        r_zero  <= 1'b1;
                        r_sim   <= '0;
                        r_state <= M_DONE;
                    end else begin
                        r_drem <= w_dge ? w_dd[AW-1:0] : w_dt[AW-1:0];
                        r_dvd  <= w_q;
                        if (r_cnt == '0) begin
                            r_zero  <= 1'b0;
                            r_sim   <= (w_q > DW'(SIM_ONE)) ? SIM_ONE : w_q[SIM_W-1:0];
                            r_state <= M_DONE;
                        end else begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                end
                M_DONE: begin
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == M_DONE);
    assign o_sim  = r_sim;
    assign o_zero = r_zero;
endmodule

[rtl/ncc_checker.sv]
// ----------------------------------------------------------------------------
// ncc_checker: port-level checks for the NCC template matcher
// Output stream handshake and result value rules, bound to the top level.
// ----------------------------------------------------------------------------
module ncc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ncc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);
    import ncc_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SIM_W-1:0] <= SIM_ONE))
        else $error("similarity above one");

    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[SIM_W-1:0] == '0))
        else $error("zero energy with nonzero similarity");
endmodule

bind ncc_template_match ncc_checker u_ncc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
